>>> rtl/core/zrt_pkg.sv
// Package for the z-ordered rectangle table: codes, state, geometry record, clamp helper.
`timescale 1ns / 1ps
`default_nettype none

package zrt_pkg;

  localparam int unsigned MaxEntriesDef = 64;

  // fixed size of a rectangle created by add
  localparam logic [11:0] AddWidth  = 12'd14;
  localparam logic [11:0] AddHeight = 12'd5;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_HIT    = 3'd1,
    FUNC_RAISE  = 3'd2,
    FUNC_RD_IDX = 3'd3,
    FUNC_RD_ID  = 3'd4,
    FUNC_WRITE  = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    CFG_MIN_WIDTH    = 3'd0,
    CFG_MIN_HEIGHT   = 3'd1,
    CFG_WORLD_LEFT   = 3'd2,
    CFG_WORLD_TOP    = 3'd3,
    CFG_WORLD_RIGHT  = 3'd4,
    CFG_WORLD_BOTTOM = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_WALK,
    S_RSHIFT,
    S_RTAIL,
    S_ROUT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [11:0] w;
    logic        [11:0] h;
  } geo_t;

  // Pull a corner back so that corner + size stays within the high bound.
  // Saturates at the low end of the 16 bit range.
  function automatic logic signed [15:0] fit_high(input logic signed [15:0] pos,
                                                  input logic        [11:0] size,
                                                  input logic signed [15:0] bound);
    logic signed [16:0] pos_x;
    logic signed [16:0] size_x;
    logic signed [16:0] bnd_x;
    logic signed [16:0] sum;
    logic signed [16:0] diff;
    logic signed [15:0] res;
    pos_x  = $signed({pos[15], pos});
    size_x = $signed({5'b0, size});
    bnd_x  = $signed({bound[15], bound});
    sum    = pos_x + size_x;
    diff   = bnd_x - size_x;
    if (sum > bnd_x) begin
      if (diff < -17'sd32768) begin
        res = -16'sd32768;
      end else begin
        res = diff[15:0];
      end
    end else begin
      res = pos;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/z_ordered_rect_table_top.sv
// Top level of the z-ordered rectangle table: stack-order and geometry memories plus sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Rectangle table kept in stacking order, bottom first.
// Input channel (in_valid_i/in_ready_o) carries one operation per transaction;
// output channel (out_valid_o/out_ready_i) returns exactly one result per operation.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i;
// only write while no operation is in flight.
// Storage: stack_mem maps stacking position -> slot, geo_mem maps slot -> geometry.
// Slot n holds the rectangle with id n+1 (entries are never removed), so an id
// maps to its slot directly. Both are synchronous RAMs.
// Path from accept to out_valid_o, by operation:
//   add, unused codes, misses on range: straight from dispatch to done
//   read by index / write: walk of a single position
//   hit test / read by id: walk of stack_mem then geo_mem, one position per
//     cycle, visiting up to entry count positions
//   raise: shift of stack_mem one entry per cycle, from the index to the top
// One operation is in flight at a time; the next is accepted once the result is
// parked in the output register, even while the receiver stalls. A stalled
// receiver holds the result; the next result waits until it is taken.
// Reset clears the entry count and loads the config registers with defaults; memory contents are
// left as is and never read before written.
module z_ordered_rect_table_top
  import zrt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  // input channel
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [2:0]         func_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic [11:0]        width_i,
  input  wire logic [11:0]        height_i,
  input  wire logic [5:0]         index_i,
  input  wire logic [6:0]         rect_id_i,
  // output channel
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               found_o,
  output      logic [5:0]         order_index_o,
  output      logic [6:0]         entry_id_o,
  output      logic signed [15:0] out_x_o,
  output      logic signed [15:0] out_y_o,
  output      logic [11:0]        out_width_o,
  output      logic [11:0]        out_height_o,
  output      logic [6:0]         entry_count_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [CW-1:0]      count_q;
  logic [11:0]        min_w_q, min_h_q;
  logic signed [15:0] left_q, top_q, right_q, bottom_q;

  // latched operation
  func_e              func_q;
  logic signed [15:0] px_q, py_q;
  logic [11:0]        w_q, h_q;
  logic [5:0]         idx_q;
  logic [6:0]         rid_q;

  // write clamp pipeline
  logic [11:0]        w_cl_q, h_cl_q;
  logic signed [15:0] x1_q, y1_q, xf_q, yf_q;

  // walk pipeline: issue -> stage 1 (slot ready) -> stage 2 (geometry ready)
  logic          issue_q;
  logic [AW-1:0] walk_pos_q, walk_end_q;
  logic          walk_dn_q;
  logic          v1_q, last1_q;
  logic [AW-1:0] pos1_q;
  logic          v2_q, last2_q;
  logic [AW-1:0] pos2_q, slot2_q;

  // raise shifter
  logic          rd_pend_q;
  logic [AW-1:0] rd_addr_q;
  logic [CW-1:0] rd_next_q;
  logic [AW-1:0] moved_q;

  // staged result
  logic          res_found_q;
  logic [AW-1:0] res_pos_q, res_slot_q;
  geo_t          res_geo_q;

  // output register
  logic               out_valid_q;
  logic               out_found_q;
  logic [5:0]         out_idx_q;
  logic [6:0]         out_id_q;
  geo_t               out_geo_q;
  logic [6:0]         out_cnt_q;

  // memories
  logic [AW-1:0] stack_mem [MAX_ENTRIES];
  geo_t          geo_mem   [MAX_ENTRIES];
  logic [AW-1:0] stack_rd_q;
  geo_t          geo_rd_q;

  logic          stack_re, stack_we;
  logic [AW-1:0] stack_ra, stack_wa, stack_wd;
  logic          geo_re, geo_we;
  logic [AW-1:0] geo_ra, geo_wa;
  geo_t          geo_wd;

  // ---------------------------------------------------------------------------
  // decode helpers
  // ---------------------------------------------------------------------------
  logic          in_fire, out_free;
  logic          full, empty, idx_ok;
  logic [AW-1:0] idx_addr, cnt_addr, top_addr;
  logic          hit_in, id_match, walk_match, walk_done, rd_more;
  geo_t          add_geo, wr_geo;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign full     = (count_q >= CW'(MAX_ENTRIES));
  assign empty    = (count_q == '0);
  assign idx_ok   = ((CW + 6)'(idx_q) < (CW + 6)'(count_q));
  assign idx_addr = AW'(idx_q);
  assign cnt_addr = count_q[AW-1:0];
  assign top_addr = AW'(count_q - CW'(1));
  assign rd_more  = (rd_next_q < count_q);

  assign add_geo = '{x: px_q, y: py_q, w: AddWidth, h: AddHeight};
  assign wr_geo  = '{x: xf_q, y: yf_q, w: w_cl_q, h: h_cl_q};

  // point in rectangle, low bound inclusive, high bound exclusive
  always_comb begin
    logic signed [16:0] px_x, py_x, rx0, ry0, rx1, ry1;
    px_x   = $signed({px_q[15], px_q});
    py_x   = $signed({py_q[15], py_q});
    rx0    = $signed({geo_rd_q.x[15], geo_rd_q.x});
    ry0    = $signed({geo_rd_q.y[15], geo_rd_q.y});
    rx1    = rx0 + $signed({5'b0, geo_rd_q.w});
    ry1    = ry0 + $signed({5'b0, geo_rd_q.h});
    hit_in = (px_x >= rx0) && (px_x < rx1) && (py_x >= ry0) && (py_x < ry1);
  end

  // id of a slot is slot + 1; only the low 7 bits take part
  assign id_match = (rid_q != '0) &&
                    (7'({1'b0, slot2_q} + (AW + 1)'(1)) == rid_q);

  always_comb begin
    unique case (func_q)
      FUNC_HIT:   walk_match = hit_in;
      FUNC_RD_ID: walk_match = id_match;
      default:    walk_match = 1'b1;
    endcase
  end

  assign walk_done = v2_q && (walk_match || last2_q);

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        unique case (func_q)
          FUNC_HIT, FUNC_RD_ID:   state_d = empty ? S_DONE : S_WALK;
          FUNC_RAISE:             state_d = idx_ok ? S_RSHIFT : S_DONE;
          FUNC_RD_IDX, FUNC_WRITE: state_d = idx_ok ? S_WALK : S_DONE;
          default:                state_d = S_DONE;
        endcase
      end
      S_WALK: begin
        if (walk_done) state_d = S_DONE;
      end
      S_RSHIFT: begin
        if (!rd_pend_q && !rd_more) state_d = S_RTAIL;
      end
      S_RTAIL: state_d = S_ROUT;
      S_ROUT:  state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // memory controls
  // ---------------------------------------------------------------------------
  always_comb begin
    stack_re = 1'b0;
    stack_ra = '0;
    stack_we = 1'b0;
    stack_wa = '0;
    stack_wd = '0;
    geo_re   = 1'b0;
    geo_ra   = '0;
    geo_we   = 1'b0;
    geo_wa   = '0;
    geo_wd   = '0;
    unique case (state_q)
      S_DISP: begin
        if (func_q == FUNC_ADD && !full) begin
          stack_we = 1'b1;
          stack_wa = cnt_addr;
          stack_wd = cnt_addr;
          geo_we   = 1'b1;
          geo_wa   = cnt_addr;
          geo_wd   = add_geo;
        end
      end
      S_WALK: begin
        stack_re = issue_q;
        stack_ra = walk_pos_q;
        geo_re   = v1_q;
        geo_ra   = stack_rd_q;
        if (v2_q && walk_match && func_q == FUNC_WRITE) begin
          geo_we = 1'b1;
          geo_wa = slot2_q;
          geo_wd = wr_geo;
        end
      end
      S_RSHIFT: begin
        // move each entry above the raised one down by one position
        stack_re = rd_more;
        stack_ra = rd_next_q[AW-1:0];
        if (rd_pend_q && rd_addr_q != idx_addr) begin
          stack_we = 1'b1;
          stack_wa = rd_addr_q - AW'(1);
          stack_wd = stack_rd_q;
        end
      end
      S_RTAIL: begin
        stack_we = 1'b1;
        stack_wa = top_addr;
        stack_wd = moved_q;
        geo_re   = 1'b1;
        geo_ra   = moved_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    if (stack_re) stack_rd_q <= stack_mem[stack_ra];
  end

  always_ff @(posedge clk_i) begin
    if (geo_we) geo_mem[geo_wa] <= geo_wd;
    if (geo_re) geo_rd_q <= geo_mem[geo_ra];
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      min_w_q     <= 12'd3;
      min_h_q     <= 12'd3;
      left_q      <= 16'sd0;
      top_q       <= 16'sd0;
      right_q     <= 16'sd4095;
      bottom_q    <= 16'sd4095;
      issue_q     <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      rd_pend_q   <= 1'b0;
      res_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MIN_WIDTH:    min_w_q  <= cfg_data_i[11:0];
          CFG_MIN_HEIGHT:   min_h_q  <= cfg_data_i[11:0];
          CFG_WORLD_LEFT:   left_q   <= cfg_data_i;
          CFG_WORLD_TOP:    top_q    <= cfg_data_i;
          CFG_WORLD_RIGHT:  right_q  <= cfg_data_i;
          CFG_WORLD_BOTTOM: bottom_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_DISP: begin
          res_found_q <= 1'b0;
          issue_q     <= 1'b1;
          v1_q        <= 1'b0;
          v2_q        <= 1'b0;
          rd_pend_q   <= 1'b0;
          if (func_q == FUNC_ADD && !full) begin
            res_found_q <= 1'b1;
            count_q     <= count_q + CW'(1);
          end
        end
        S_WALK: begin
          if (issue_q) issue_q <= (walk_pos_q != walk_end_q);
          v1_q <= issue_q;
          v2_q <= v1_q;
          if (v2_q && walk_match) res_found_q <= 1'b1;
        end
        S_RSHIFT: rd_pend_q <= rd_more;
        S_ROUT:   res_found_q <= 1'b1;
        default: ;
      endcase

      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_e'(func_i);
      px_q   <= pos_x_i;
      py_q   <= pos_y_i;
      w_q    <= width_i;
      h_q    <= height_i;
      idx_q  <= index_i;
      rid_q  <= rect_id_i;
    end

    // write clamp: minimum size and low bounds, then high bounds
    w_cl_q <= (w_q < min_w_q) ? min_w_q : w_q;
    h_cl_q <= (h_q < min_h_q) ? min_h_q : h_q;
    x1_q   <= (px_q < left_q) ? left_q : px_q;
    y1_q   <= (py_q < top_q) ? top_q : py_q;
    xf_q   <= fit_high(x1_q, w_cl_q, right_q);
    yf_q   <= fit_high(y1_q, h_cl_q, bottom_q);

    unique case (state_q)
      S_DISP: begin
        res_pos_q  <= cnt_addr;
        res_slot_q <= cnt_addr;
        res_geo_q  <= add_geo;
        rd_next_q  <= CW'(idx_q);
        if (func_q == FUNC_HIT) begin
          walk_pos_q <= top_addr;
          walk_end_q <= '0;
          walk_dn_q  <= 1'b1;
        end else if (func_q == FUNC_RD_ID) begin
          walk_pos_q <= '0;
          walk_end_q <= top_addr;
          walk_dn_q  <= 1'b0;
        end else begin
          walk_pos_q <= idx_addr;
          walk_end_q <= idx_addr;
          walk_dn_q  <= 1'b0;
        end
      end
      S_WALK: begin
        if (issue_q) walk_pos_q <= walk_dn_q ? walk_pos_q - AW'(1) : walk_pos_q + AW'(1);
        pos1_q  <= walk_pos_q;
        last1_q <= (walk_pos_q == walk_end_q);
        pos2_q  <= pos1_q;
        last2_q <= last1_q;
        slot2_q <= stack_rd_q;
        if (v2_q && walk_match) begin
          res_pos_q  <= pos2_q;
          res_slot_q <= slot2_q;
          res_geo_q  <= (func_q == FUNC_WRITE) ? wr_geo : geo_rd_q;
        end
      end
      S_RSHIFT: begin
        if (rd_pend_q && rd_addr_q == idx_addr) moved_q <= stack_rd_q;
        if (rd_more) begin
          rd_addr_q <= rd_next_q[AW-1:0];
          rd_next_q <= rd_next_q + CW'(1);
        end
      end
      S_ROUT: begin
        res_pos_q  <= top_addr;
        res_slot_q <= moved_q;
        res_geo_q  <= geo_rd_q;
      end
      default: ;
    endcase

    if (state_q == S_DONE && out_free) begin
      out_found_q <= res_found_q;
      out_idx_q   <= res_found_q ? 6'(res_pos_q) : 6'd0;
      out_id_q    <= res_found_q ? 7'({1'b0, res_slot_q} + (AW + 1)'(1)) : 7'd0;
      out_geo_q   <= res_found_q ? res_geo_q : '0;
      out_cnt_q   <= 7'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign order_index_o = out_idx_q;
  assign entry_id_o    = out_id_q;
  assign out_x_o       = out_geo_q.x;
  assign out_y_o       = out_geo_q.y;
  assign out_width_o   = out_geo_q.w;
  assign out_height_o  = out_geo_q.h;
  assign entry_count_o = out_cnt_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_DISP)
    else $error("accepted transaction not dispatched");

  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISP && func_q == FUNC_ADD && !full) |=>
      count_q == $past(count_q) + CW'(1))
    else $error("add did not bump the entry count");

  a_count_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DISP) |=> $stable(count_q))
    else $error("entry count changed outside add");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_q && state_q == S_IDLE)
    else $error("finished result not presented");

endmodule

`default_nettype wire

>>> verif/tb_z_ordered_rect_table_top.sv
// Testbench for z_ordered_rect_table_top: shadow rectangle table, stimulus and reply checks.
`timescale 1ns / 1ps

// Self-checking bench. A shadow copy of the rectangle table lives in a small
// class. Every accepted operation updates the shadow and queues the reply the
// block owes. Every reply taken from the block is compared field by field
// against the oldest queued reply.
module tb_z_ordered_rect_table_top
  import zrt_pkg::*;
();

  localparam int MaxEntries  = MaxEntriesDef;
  localparam int CycleLimit  = 1500000;
  localparam int LongHold    = 400;    // receiver hold-off, in cycles
  localparam int PhaseOps    = 245;
  localparam int DrainCycles = 100;    // idle time after the final drain

  // func codes the block does not implement
  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  // one operation as presented on the input channel
  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [11:0]        width;
    logic [11:0]        height;
    logic [5:0]         index;
    logic [6:0]         rect_id;
  } rect_op_t;

  // one reply as seen on the output channel
  typedef struct packed {
    logic               found;
    logic [5:0]         order_index;
    logic [6:0]         entry_id;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [6:0]         count;
  } rect_reply_t;

  // shadow entry, kept in plain integers so clamp math cannot wrap
  typedef struct {
    int id;
    int x;
    int y;
    int w;
    int h;
  } rect_entry_t;

  // Shadow of the table plus the replies still owed by the block.
  class zrect_table_shadow;
    rect_entry_t stack[$];        // bottom first
    rect_reply_t replies_due[$];
    int min_w, min_h, w_left, w_top, w_right, w_bottom;
    int fail_cnt;

    function new();
      min_w    = 3;
      min_h    = 3;
      w_left   = 0;
      w_top    = 0;
      w_right  = 4095;
      w_bottom = 4095;
      fail_cnt = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_MIN_WIDTH:    min_w    = int'(val[11:0]);
        CFG_MIN_HEIGHT:   min_h    = int'(val[11:0]);
        CFG_WORLD_LEFT:   w_left   = int'($signed(val));
        CFG_WORLD_TOP:    w_top    = int'($signed(val));
        CFG_WORLD_RIGHT:  w_right  = int'($signed(val));
        CFG_WORLD_BOTTOM: w_bottom = int'($signed(val));
        default: ;
      endcase
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Apply one accepted operation to the shadow and queue its reply.
    function void apply_op(rect_op_t op);
      rect_entry_t e;
      rect_reply_t res;
      int n, hit, i, px, py, idx, wv, hv, xv, yv;
      n   = stack.size();
      hit = -1;
      px  = int'($signed(op.pos_x));
      py  = int'($signed(op.pos_y));
      idx = int'(op.index);
      case (op.func)
        FUNC_ADD: begin
          if (n < MaxEntries) begin
            e.id = n + 1;
            e.x  = px;
            e.y  = py;
            e.w  = int'(AddWidth);
            e.h  = int'(AddHeight);
            stack.push_back(e);
            hit = n;
          end
        end
        FUNC_HIT: begin
          // topmost first; low bound inclusive, high bound exclusive
          for (i = n - 1; i >= 0 && hit < 0; i--) begin
            if (px >= stack[i].x && px < stack[i].x + stack[i].w &&
                py >= stack[i].y && py < stack[i].y + stack[i].h) begin
              hit = i;
            end
          end
        end
        FUNC_RAISE: begin
          if (idx < n) begin
            e = stack[idx];
            stack.delete(idx);
            stack.push_back(e);
            hit = n - 1;
          end
        end
        FUNC_RD_IDX: begin
          if (idx < n) begin
            hit = idx;
          end
        end
        FUNC_RD_ID: begin
          if (op.rect_id != '0) begin
            for (i = 0; i < n && hit < 0; i++) begin
              if (stack[i].id == int'(op.rect_id)) begin
                hit = i;
              end
            end
          end
        end
        FUNC_WRITE: begin
          if (idx < n) begin
            // size first, then low world bounds, then high bounds
            wv = int'(op.width);
            hv = int'(op.height);
            if (wv < min_w) wv = min_w;
            if (hv < min_h) hv = min_h;
            xv = px;
            yv = py;
            if (xv < w_left) xv = w_left;
            if (yv < w_top) yv = w_top;
            if (xv + wv > w_right) xv = w_right - wv;
            if (yv + hv > w_bottom) yv = w_bottom - hv;
            if (xv < -32768) xv = -32768;
            if (xv > 32767) xv = 32767;
            if (yv < -32768) yv = -32768;
            if (yv > 32767) yv = 32767;
            e    = stack[idx];
            e.x  = xv;
            e.y  = yv;
            e.w  = wv;
            e.h  = hv;
            stack[idx] = e;
            hit = idx;
          end
        end
        default: ;
      endcase
      res       = '0;
      res.count = 7'(stack.size());
      if (hit >= 0) begin
        res.found       = 1'b1;
        res.order_index = 6'(hit);
        res.entry_id    = 7'(stack[hit].id);
        res.x           = 16'(stack[hit].x);
        res.y           = 16'(stack[hit].y);
        res.w           = 12'(stack[hit].w);
        res.h           = 12'(stack[hit].h);
      end
      replies_due.push_back(res);
    endfunction

    function string fmt(rect_reply_t r);
      return $sformatf("found=%0d idx=%0d id=%0d x=%0d y=%0d w=%0d h=%0d cnt=%0d",
                       r.found, r.order_index, r.entry_id, r.x, r.y, r.w, r.h,
                       r.count);
    endfunction

    function void check_reply(rect_reply_t got);
      rect_reply_t want;
      if (replies_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("reply with nothing owed: %s", fmt(got));
        return;
      end
      want = replies_due.pop_front();
      if (got.found !== want.found || got.order_index !== want.order_index ||
          got.entry_id !== want.entry_id || got.x !== want.x || got.y !== want.y ||
          got.w !== want.w || got.h !== want.h || got.count !== want.count) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("reply mismatch at %0t\n  expected %s\n  actual   %s",
                   $realtime, fmt(want), fmt(got));
        end
      end
    endfunction
  endclass

  // clock, reset and all block inputs start at known values
  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [2:0]  cfg_idx_i  = CFG_MIN_WIDTH;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic [2:0]  func_i     = FUNC_ADD;
  logic signed [15:0] pos_x_i = '0;
  logic signed [15:0] pos_y_i = '0;
  logic [11:0] width_i    = '0;
  logic [11:0] height_i   = '0;
  logic [5:0]  index_i    = '0;
  logic [6:0]  rect_id_i  = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic        found_o;
  logic [5:0]  order_index_o;
  logic [6:0]  entry_id_o;
  logic signed [15:0] out_x_o;
  logic signed [15:0] out_y_o;
  logic [11:0] out_width_o;
  logic [11:0] out_height_o;
  logic [6:0]  entry_count_o;

  zrect_table_shadow shadow;
  logic burst    = 1'b0;   // no idling on either side while set
  logic hold_req = 1'b0;   // asks the receiver for one long hold-off

  always #1 clk_i = ~clk_i;

  z_ordered_rect_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .width_i       (width_i),
    .height_i      (height_i),
    .index_i       (index_i),
    .rect_id_i     (rect_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .order_index_o (order_index_o),
    .entry_id_o    (entry_id_o),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .out_width_o   (out_width_o),
    .out_height_o  (out_height_o),
    .entry_count_o (entry_count_o)
  );

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // Coordinates: mostly a crowded patch so rectangles overlap, some extremes.
  function automatic logic [15:0] pick_coord();
    int k, v;
    k = $urandom_range(0, 19);
    if (k < 4) begin
      v = $urandom_range(0, 65535);
    end else if (k < 6) begin
      case ($urandom_range(0, 3))
        0:       v = -32768;
        1:       v = -32767;
        2:       v = 32766;
        default: v = 32767;
      endcase
    end else begin
      v = $urandom_range(0, 900) - 300;
    end
    return 16'(v);
  endfunction

  // Probe on or next to an edge of a span, or somewhere inside it.
  function automatic logic [15:0] near_edge(int p, int s);
    int v;
    case ($urandom_range(0, 4))
      0:       v = p - 1;
      1:       v = p;
      2:       v = p + s - 1;
      3:       v = p + s;
      default: v = p + $urandom_range(0, s - 1);
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic rect_op_t mk_op(logic [2:0] func, int x, int y, int w, int h,
                                     int idx, int id);
    rect_op_t op;
    op.func    = func;
    op.pos_x   = 16'(x);
    op.pos_y   = 16'(y);
    op.width   = 12'(w);
    op.height  = 12'(h);
    op.index   = 6'(idx);
    op.rect_id = 7'(id);
    return op;
  endfunction

  // Random operation. Most are well formed against the current shadow
  // (valid positions, known ids, probes near edges); a few are pure noise.
  function automatic rect_op_t gen_op();
    rect_op_t op;
    logic [31:0] a, b, c;
    int n, r, e;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    n = shadow.stack.size();
    op.pos_x   = a[15:0];
    op.pos_y   = a[31:16];
    op.width   = b[11:0];
    op.height  = b[23:12];
    op.index   = b[29:24];
    op.rect_id = c[6:0];
    op.func    = c[9:7];
    r = $urandom_range(0, 99);
    if (r < 94) begin
      if (r < 15)      op.func = FUNC_ADD;
      else if (r < 40) op.func = FUNC_HIT;
      else if (r < 52) op.func = FUNC_RAISE;
      else if (r < 64) op.func = FUNC_RD_IDX;
      else if (r < 76) op.func = FUNC_RD_ID;
      else             op.func = FUNC_WRITE;
      op.pos_x = pick_coord();
      op.pos_y = pick_coord();
      if (n > 0 && $urandom_range(0, 9) < 8) op.index = 6'($urandom_range(0, n - 1));
      if (n > 0 && $urandom_range(0, 9) < 8) op.rect_id = 7'($urandom_range(1, n));
      if ($urandom_range(0, 9) < 4) begin
        op.width  = 12'($urandom_range(0, 24));
        op.height = 12'($urandom_range(0, 24));
      end
      if (op.func == FUNC_HIT && n > 0 && $urandom_range(0, 3) != 0) begin
        e = $urandom_range(0, n - 1);
        op.pos_x = near_edge(shadow.stack[e].x, shadow.stack[e].w);
        op.pos_y = near_edge(shadow.stack[e].y, shadow.stack[e].h);
      end
    end
    return op;
  endfunction

  // Present one transaction after an optional gap; returns at a falling edge.
  task automatic send_op(input rect_op_t op, input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= op.func;
    pos_x_i    <= op.pos_x;
    pos_y_i    <= op.pos_y;
    width_i    <= op.width;
    height_i   <= op.height;
    index_i    <= op.index;
    rect_id_i  <= op.rect_id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shadow.apply_op(op);
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every owed reply has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 16'(val);
    shadow.set_reg(idx, 16'(val));
    @(negedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic set_regs(input int mw, mh, lf, tp, rt, bt);
    write_reg(CFG_MIN_WIDTH, mw);
    write_reg(CFG_MIN_HEIGHT, mh);
    write_reg(CFG_WORLD_LEFT, lf);
    write_reg(CFG_WORLD_TOP, tp);
    write_reg(CFG_WORLD_RIGHT, rt);
    write_reg(CFG_WORLD_BOTTOM, bt);
    cfg_we_i <= 1'b0;
  endtask

  // Directed part, run with the reset register values.
  task automatic run_directed();
    // empty table: nothing to hit, raise, read or write
    send_op(mk_op(FUNC_HIT, 0, 0, 0, 0, 0, 1), pick_gap());
    send_op(mk_op(FUNC_RAISE, 0, 0, 0, 0, 0, 1), pick_gap());
    send_op(mk_op(FUNC_RD_IDX, 0, 0, 0, 0, 0, 1), pick_gap());
    send_op(mk_op(FUNC_WRITE, 5, 5, 20, 20, 0, 1), pick_gap());
    send_op(mk_op(FUNC_RD_ID, 0, 0, 0, 0, 0, 0), pick_gap());
    // adds at the coordinate extremes and two overlapping ones
    send_op(mk_op(FUNC_ADD, -32768, -32768, 0, 0, 0, 0), pick_gap());
    send_op(mk_op(FUNC_ADD, 32767, 32767, 4095, 4095, 63, 127), pick_gap());
    send_op(mk_op(FUNC_ADD, 100, 200, 0, 0, 0, 0), pick_gap());
    send_op(mk_op(FUNC_ADD, 105, 202, 0, 0, 0, 0), pick_gap());
    // hit edges: low bound inclusive, high bound exclusive, overlap picks top
    send_op(mk_op(FUNC_HIT, 100, 200, 0, 0, 0, 0), pick_gap());
    send_op(mk_op(FUNC_HIT, 113, 204, 0, 0, 0, 0), pick_gap());
    send_op(mk_op(FUNC_HIT, 119, 206, 0, 0, 0, 0), pick_gap());
    send_op(mk_op(FUNC_HIT, 100, 205, 0, 0, 0, 0), pick_gap());
    send_op(mk_op(FUNC_HIT, 32767, 32767, 0, 0, 0, 0), pick_gap());
    send_op(mk_op(FUNC_HIT, -32768, -32768, 0, 0, 0, 0), pick_gap());
    // raise bottom to top, read the top by index, then two reads by id
    send_op(mk_op(FUNC_RAISE, 0, 0, 0, 0, 0, 0), pick_gap());
    send_op(mk_op(FUNC_RD_IDX, 0, 0, 0, 0, 3, 0), pick_gap());
    send_op(mk_op(FUNC_RD_ID, 0, 0, 0, 0, 0, 2), pick_gap());
    send_op(mk_op(FUNC_RD_ID, 0, 0, 0, 0, 0, 127), pick_gap());
    // writes: below minimum size and world, past the high bounds
    send_op(mk_op(FUNC_WRITE, -32768, -32768, 0, 0, 1, 0), pick_gap());
    send_op(mk_op(FUNC_WRITE, 32767, 32767, 4095, 4095, 2, 0), pick_gap());
    send_op(mk_op(FUNC_WRITE, 4000, 10, 200, 4095, 0, 0), pick_gap());
    // unused codes, stale position, raise of the top entry
    send_op(mk_op(FUNC_SPARE_A, 100, 200, 14, 5, 0, 1), pick_gap());
    send_op(mk_op(FUNC_SPARE_B, 100, 200, 14, 5, 0, 1), pick_gap());
    send_op(mk_op(FUNC_RAISE, 0, 0, 0, 0, 63, 0), pick_gap());
    send_op(mk_op(FUNC_RAISE, 0, 0, 0, 0, 3, 0), pick_gap());
  endtask

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Reply monitor: one reply per output transaction.
  initial begin : reply_monitor
    rect_reply_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.found       = found_o;
        got.order_index = order_index_o;
        got.entry_id    = entry_id_o;
        got.x           = out_x_o;
        got.y           = out_y_o;
        got.w           = out_width_o;
        got.h           = out_height_o;
        got.count       = entry_count_o;
        shadow.check_reply(got);
      end
    end
  end

  // Hang guard.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus: directed part, then six register settings with random traffic.
  initial begin : stimulus
    int ph, k, lf, tp;
    shadow = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (ph = 0; ph < 6; ph++) begin
      drain();
      lf = $urandom_range(0, 1000) - 500;
      tp = $urandom_range(0, 1000) - 500;
      case (ph)
        0: set_regs(1, 1, -32768, -32768, 32767, 32767);
        1: set_regs(4095, 4095, 32767, 32767, -32768, -32768);
        4: set_regs(4095, 1, -100, -50, 700, 400);
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            set_regs($urandom_range(1, 4095), $urandom_range(1, 4095),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535));
          end else begin
            set_regs($urandom_range(1, 20), $urandom_range(1, 20), lf, tp,
                     lf + $urandom_range(0, 3000), tp + $urandom_range(0, 3000));
          end
        end
      endcase
      burst = (ph == 3);
      for (k = 0; k < PhaseOps; k++) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 1 && k == 40) hold_req = 1'b1;
        // sender pause until every owed reply is back
        if (ph == 2 && k == 120) drain();
        send_op(gen_op(), pick_gap());
      end
    end
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (shadow.fail_cnt == 0 && shadow.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/zrt_pkg.sv
rtl/core/z_ordered_rect_table_top.sv
verif/tb_z_ordered_rect_table_top.sv
